// ===== hdl/vertex_scale_rotate_translate_unit_defines.svh =====
// Assertion macros shared by the vertex transform RTL.
`ifndef VERTEX_SCALE_ROTATE_TRANSLATE_UNIT_DEFINES_SVH
`define VERTEX_SCALE_ROTATE_TRANSLATE_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define VSRT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vsrt assertion failed");

// Antecedent implies consequent in the next cycle.
`define VSRT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vsrt assertion failed");

`endif

// ===== hdl/vsrt_pkg.sv =====
// Types, constants and the sine table of the vertex transform unit.
package vsrt_pkg;

  localparam int ANGLE_BITS = 12;
  localparam int QUARTER    = 1 << (ANGLE_BITS - 2);
  localparam int IDX_W      = ANGLE_BITS - 1;
  localparam int SINE_W     = 16;
  localparam int COEF_W     = 18;
  localparam int MACC_W     = 37;
  localparam int SCALED_W   = 40;
  localparam int PROD_W     = SCALED_W + COEF_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam longint unsigned HALF_PI_Q46 = 64'h1921FB54442D1846 >> 14;

  typedef logic [SINE_W-1:0] sine_tab_t [0:QUARTER];
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic signed [31:0] vin_x;
    logic signed [31:0] vin_y;
    logic signed [31:0] vin_z;
  } vin_t;

  typedef struct packed {
    logic signed [31:0] vout_x;
    logic signed [31:0] vout_y;
    logic signed [31:0] vout_z;
  } vout_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE  = 3'd0,
    REG_ANGLES = 3'd1,
    REG_OFF_X  = 3'd2,
    REG_OFF_Y  = 3'd3,
    REG_OFF_Z  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {CF_IDLE, CF_READ, CF_MAC} coef_state_t;
  typedef enum logic [1:0] {MAC_SET, MAC_ADD, MAC_SUB} mac_op_t;
  typedef enum logic [3:0] {
    D_NONE, D_SXSY, D_CXSY, D_M00, D_M01, D_M02, D_M10, D_M11, D_M12, D_M21, D_M22
  } coef_dst_t;

  // Sine/cosine register slots, in table read order.
  localparam logic [2:0] SC_SX = 3'd0;
  localparam logic [2:0] SC_CX = 3'd1;
  localparam logic [2:0] SC_SY = 3'd2;
  localparam logic [2:0] SC_CY = 3'd3;
  localparam logic [2:0] SC_SZ = 3'd4;
  localparam logic [2:0] SC_CZ = 3'd5;
  localparam logic [3:0] READ_LAST = 4'd6;
  localparam logic [3:0] MAC_LAST  = 4'd13;

  // Per-lane pipeline enables.
  typedef struct packed {
    logic en1;
    logic en2;
  } lane_ctl_t;

  typedef struct packed {
    logic en3;
    logic en4;
  } merge_ctl_t;

  // Quarter-wave table, Taylor series in Q2.30 with truncating steps.
  function automatic sine_tab_t build_sine();
    sine_tab_t       tab;
    longint unsigned theta;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          e;
    for (int k = 0; k <= QUARTER; k++) begin
      theta = (64'(k) * HALF_PI_Q46) >> (16 + ANGLE_BITS - 2);
      x2    = (theta * theta) >> 30;
      term  = theta;
      sum   = longint'(theta);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n & 1) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      e = (sum + 16384) >>> 15;
      if (e > 32768) e = 32768;
      tab[k] = SINE_W'(e);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // 12-bit configured angle to table angle.
  function automatic logic [ANGLE_BITS-1:0] table_angle(input logic [11:0] a12);
    logic [ANGLE_BITS+11:0] w;
    w = {a12, {ANGLE_BITS{1'b0}}} >> 12;
    return w[ANGLE_BITS-1:0];
  endfunction

endpackage

// ===== hdl/vsrt_coef.sv =====
// Rotation matrix builder: sine table reads and a shared multiply-accumulate.
module vsrt_coef import vsrt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [35:0] angles,
  output logic        busy,
  output coef_t       m [3][3]
);

  coef_state_t state, state_next;
  logic [3:0]  cnt, cnt_next;

  logic [SINE_W-1:0] rom_q;
  logic              rom_neg;
  logic [2:0]        rom_code;
  coef_t             sc [6];
  coef_t             sxsy, cxsy;
  logic signed [MACC_W-1:0] acc, nsum;
  logic signed [2*COEF_W-1:0] prod;

  logic [1:0]            field;
  logic [ANGLE_BITS-1:0] ang;
  logic [1:0]            quad;
  logic [IDX_W-1:0]      rem, idx;

  coef_t     opa, opb;
  mac_op_t   op;
  coef_dst_t dst;
  coef_t     res;

  // Next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt + 4'd1;
    unique case (state)
      CF_IDLE: cnt_next = '0;
      CF_READ: if (cnt == READ_LAST) begin
        state_next = CF_MAC;
        cnt_next   = '0;
      end
      CF_MAC: if (cnt == MAC_LAST) begin
        state_next = CF_IDLE;
        cnt_next   = '0;
      end
      default: begin
        state_next = CF_IDLE;
        cnt_next   = '0;
      end
    endcase
    if (start) begin
      state_next = CF_READ;
      cnt_next   = '0;
    end
  end

  // Outputs
  always_comb begin
    busy = (state != CF_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CF_READ;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Table address for the slot being issued
  always_comb begin
    field = cnt[2:1];
    ang   = table_angle(angles[12*field +: 12]);
    if (cnt[0]) ang = ang + ANGLE_BITS'(QUARTER);
    quad = ang[ANGLE_BITS-1 -: 2];
    rem  = IDX_W'(ang[ANGLE_BITS-3:0]);
    idx  = quad[0] ? IDX_W'(QUARTER) - rem : rem;
  end

  always_ff @(posedge clk) begin
    rom_q    <= SINE_TAB[idx];
    rom_neg  <= quad[1];
    rom_code <= cnt[2:0];
    if (state == CF_READ && cnt != '0) begin
      sc[rom_code] <= rom_neg ? -coef_t'({1'b0, rom_q}) : coef_t'({1'b0, rom_q});
    end
  end

  // Step program of the multiply-accumulate
  always_comb begin
    opa = '0;
    opb = '0;
    op  = MAC_SET;
    dst = D_NONE;
    unique case (cnt)
      4'd0:  begin opa = sc[SC_SX]; opb = sc[SC_SY]; dst = D_SXSY; end
      4'd1:  begin opa = sc[SC_CX]; opb = sc[SC_SY]; dst = D_CXSY; end
      4'd2:  begin opa = sc[SC_CY]; opb = sc[SC_CZ]; dst = D_M00;  end
      4'd3:  begin opa = sxsy;      opb = sc[SC_CZ]; end
      4'd4:  begin opa = sc[SC_CX]; opb = sc[SC_SZ]; op = MAC_SUB; dst = D_M01; end
      4'd5:  begin opa = cxsy;      opb = sc[SC_CZ]; end
      4'd6:  begin opa = sc[SC_SX]; opb = sc[SC_SZ]; op = MAC_ADD; dst = D_M02; end
      4'd7:  begin opa = sc[SC_CY]; opb = sc[SC_SZ]; dst = D_M10;  end
      4'd8:  begin opa = sxsy;      opb = sc[SC_SZ]; end
      4'd9:  begin opa = sc[SC_CX]; opb = sc[SC_CZ]; op = MAC_ADD; dst = D_M11; end
      4'd10: begin opa = cxsy;      opb = sc[SC_SZ]; end
      4'd11: begin opa = sc[SC_SX]; opb = sc[SC_CZ]; op = MAC_SUB; dst = D_M12; end
      4'd12: begin opa = sc[SC_SX]; opb = sc[SC_CY]; dst = D_M21;  end
      4'd13: begin opa = sc[SC_CX]; opb = sc[SC_CY]; dst = D_M22;  end
      default: ;
    endcase
    prod = opa * opb;
    unique case (op)
      MAC_ADD: nsum = acc + MACC_W'(prod);
      MAC_SUB: nsum = acc - MACC_W'(prod);
      default: nsum = MACC_W'(prod);
    endcase
    res = COEF_W'(nsum >>> 15);
  end

  always_ff @(posedge clk) begin
    if (state == CF_MAC) begin
      acc <= nsum;
      if (cnt == '0) m[2][0] <= -sc[SC_SY];
      unique case (dst)
        D_SXSY: sxsy    <= res;
        D_CXSY: cxsy    <= res;
        D_M00:  m[0][0] <= res;
        D_M01:  m[0][1] <= res;
        D_M02:  m[0][2] <= res;
        D_M10:  m[1][0] <= res;
        D_M11:  m[1][1] <= res;
        D_M12:  m[1][2] <= res;
        D_M21:  m[2][1] <= res;
        D_M22:  m[2][2] <= res;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/vsrt_lane.sv =====
// One axis lane: scale the coordinate, then multiply by its matrix column.
module vsrt_lane import vsrt_pkg::*; (
  input  logic               clk,
  input  lane_ctl_t          ctl,
  input  logic signed [31:0] coord,
  input  logic signed [15:0] factor,
  input  coef_t              col [3],
  output prod_t              p [3]
);

  logic signed [SCALED_W-1:0] s;
  logic signed [47:0]         sprod;

  assign sprod = coord * factor;

  always_ff @(posedge clk) begin
    if (ctl.en1) s <= SCALED_W'(sprod >>> 8);
    if (ctl.en2) begin
      for (int i = 0; i < 3; i++) p[i] <= col[i] * s;
    end
  end

endmodule

// ===== hdl/vsrt_merge.sv =====
// Merge stage: sum lane products per row, drop the fraction, offset, saturate.
module vsrt_merge import vsrt_pkg::*; (
  input  logic               clk,
  input  merge_ctl_t         ctl,
  input  prod_t              p [3][3],
  input  logic signed [31:0] off [3],
  output vout_t              vout
);

  localparam int RS_W = SUM_W - 15;

  logic signed [SUM_W-1:0]  sum [3];
  logic signed [RS_W:0]     tot [3];
  logic signed [31:0]       sat [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i] = (RS_W + 1)'(sum[i] >>> 15) + (RS_W + 1)'(off[i]);
      if (tot[i] > (RS_W + 1)'(32'sh7FFFFFFF)) sat[i] = 32'sh7FFFFFFF;
      else if (tot[i] < -(RS_W + 1)'(64'sh80000000)) sat[i] = 32'sh80000000;
      else sat[i] = tot[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      for (int i = 0; i < 3; i++) begin
        sum[i] <= SUM_W'(p[0][i]) + SUM_W'(p[1][i]) + SUM_W'(p[2][i]);
      end
    end
    if (ctl.en4) begin
      vout.vout_x <= sat[0];
      vout.vout_y <= sat[1];
      vout.vout_z <= sat[2];
    end
  end

endmodule

// ===== hdl/vertex_scale_rotate_translate_unit.sv =====
// Vertex scale, Euler XYZ rotate and translate unit, top level.
//
// Each beat on vin carries one Q16.16 vertex; each beat on vout carries the
// transformed vertex: every axis scaled by its Q8.8 factor, rotated by the
// matrix built from the three configured 12-bit angles (4096 = full turn),
// offset by the configured position and saturated to 32 bits. The datapath
// runs three axis lanes side by side (scale multiply, then the column of
// matrix products) and a merge stage that sums the rows, adds the offset and
// clamps. One vertex is taken per clock while vin_stall is low. Each stage
// holds only while the next one is full and stalled, so bubbles collapse.
// The matrix is built by a single shared 18x18 multiply-accumulate fed
// from the quarter-wave sine table: after reset and after each write of
// the angle register it runs seven table reads, then fourteen multiply
// steps, during which vin is stalled. Registers are to be written through
// cfg_we / cfg_index / cfg_data only while no vertex is in flight; the
// block does not enforce it. Indexes beyond the offset of z are dropped.
module vertex_scale_rotate_translate_unit
  import vsrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  vin_t                  vin,
  input  logic                  vin_valid,
  output logic                  vin_stall,
  output vout_t                 vout,
  output logic                  vout_valid,
  input  logic                  vout_stall,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "vertex_scale_rotate_translate_unit_defines.svh"

  // Configuration registers
  logic [47:0]        scale;
  logic [35:0]        angles;
  logic signed [31:0] off [3];

  logic       start;
  logic       busy;
  coef_t      m [3][3];

  // Stage valids: scale, products, row sums, output
  logic       v1, v2, v3, v4;
  lane_ctl_t  lctl;
  merge_ctl_t mctl;
  logic       accept;

  prod_t              lane_p [3][3];
  logic signed [31:0] coord [3];
  coef_t              col [3][3];

  assign start = cfg_we && (cfg_index == REG_ANGLES);

  always_ff @(posedge clk) begin
    if (rst) begin
      scale  <= 48'h010001000100;
      angles <= '0;
      off[0] <= '0;
      off[1] <= '0;
      off[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE:  scale  <= cfg_data[47:0];
        REG_ANGLES: angles <= cfg_data[35:0];
        REG_OFF_X:  off[0] <= cfg_data[31:0];
        REG_OFF_Y:  off[1] <= cfg_data[31:0];
        REG_OFF_Z:  off[2] <= cfg_data[31:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Stage enables: advance a stage when it is empty or the next one moves
  assign mctl.en4 = !v4 || !vout_stall;
  assign mctl.en3 = !v3 || mctl.en4;
  assign lctl.en2 = !v2 || mctl.en3;
  assign lctl.en1 = !v1 || lctl.en2;

  assign vin_stall  = busy || start || !lctl.en1;
  assign accept     = vin_valid && !vin_stall;
  assign vout_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (lctl.en1) v1 <= accept;
      if (lctl.en2) v2 <= v1;
      if (mctl.en3) v3 <= v2;
      if (mctl.en4) v4 <= v3;
    end
  end

  vsrt_coef u_coef (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .angles (angles),
    .busy   (busy),
    .m      (m)
  );

  assign coord[0] = vin.vin_x;
  assign coord[1] = vin.vin_y;
  assign coord[2] = vin.vin_z;

  for (genvar j = 0; j < 3; j++) begin : g_lane
    for (genvar i = 0; i < 3; i++) begin : g_col
      assign col[j][i] = m[i][j];
    end

    vsrt_lane u_lane (
      .clk    (clk),
      .ctl    (lctl),
      .coord  (coord[j]),
      .factor (scale[16*j +: 16]),
      .col    (col[j]),
      .p      (lane_p[j])
    );
  end

  vsrt_merge u_merge (
    .clk  (clk),
    .ctl  (mctl),
    .p    (lane_p),
    .off  (off),
    .vout (vout)
  );

  // No vertex enters while the matrix is being rebuilt
  `VSRT_ASSERT_IMP(a_no_accept_busy, clk, rst, accept, !busy)
  // An accepted beat occupies the first stage next cycle
  `VSRT_ASSERT_NXT(a_accept_fills, clk, rst, accept, v1)
  // A full row-sum stage behind a held output stage keeps its beat
  `VSRT_ASSERT_NXT(a_hold_sum, clk, rst, v3 && !mctl.en4, v3)

endmodule
